FILE: hw/rtl/sple_pkg.sv
// shared types and constants of the sphere/plane level-set evaluator
package sple_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned UnitBits  = 28;
  localparam int unsigned LevelBits = 16;
  localparam int unsigned SerTerms  = 14;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgPlaneX      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPlaneY      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPlaneZ      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgNormalX     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNormalY     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgNormalZ     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgEpsilon     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSphereCount = 3'd7;

  // item commands
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEval = 1'b1;

  // reset values
  localparam logic signed [31:0] NormalYReset = 32'sd1 <<< FracBits;
  localparam logic [30:0]        EpsReset     = 31'((64'd1 << FracBits) / 100);

  // divider widths and quotient lengths
  localparam int unsigned DivNumW  = 64;
  localparam int unsigned DivDenW  = 34;
  localparam int unsigned DivQW    = 34;
  localparam logic [5:0]  QbUnit   = 6'd29;
  localparam logic [5:0]  QbExp    = 6'd20;
  localparam logic [5:0]  QbSeries = 6'd33;
  localparam logic [5:0]  QbLevel  = 6'd17;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
    logic [5:0]         qbits;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SPH_RD,
    ST_SPH_DIFF,
    ST_NORM_LOAD,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_UNIT_GO,
    ST_UNIT_WAIT,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_PLANE_DONE,
    ST_EXP_START,
    ST_EXP_GO,
    ST_EXP_WAIT,
    ST_SER_INIT,
    ST_SER_MUL,
    ST_SER_DIV_GO,
    ST_SER_DIV_WAIT,
    ST_SER_END,
    ST_POW_MUL,
    ST_POW_ACC,
    ST_LVL_GO,
    ST_LVL_WAIT,
    ST_OUT
  } state_e;

endpackage

FILE: hw/rtl/sple_if.sv
// item and result channel interfaces
interface sple_item_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [3:0]         slot;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [30:0]        radius;

  modport source (output valid, cmd, slot, pos_x, pos_y, pos_z, radius, input ready);
  modport sink   (input valid, cmd, slot, pos_x, pos_y, pos_z, radius, output ready);
endinterface

interface sple_result_if;
  logic        valid;
  logic        ready;
  logic [16:0] level;

  modport source (output valid, level, input ready);
  modport sink   (input valid, level, output ready);
endinterface

FILE: hw/rtl/sple_div.sv
// restoring divider, one quotient bit per cycle
module sple_div
  import sple_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DivQW-1:0] quot_o
);

  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivNumW-1:0] sh_q;
  logic [DivQW-1:0]   quot_q;
  logic [5:0]         cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [DivDenW:0]   trial;
  logic               ge;

  assign trial = {rem_q, sh_q[DivNumW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.qbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= DivDenW'(req_i.num >> req_i.qbits);
      sh_q   <= req_i.num << (7'd64 - {1'b0, req_i.qbits});
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
      sh_q   <= sh_q << 1;
      quot_q <= {quot_q[DivQW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: hw/rtl/sple_sqrt.sv
// floor square root of a 64-bit value, one root bit per cycle
module sple_sqrt
  import sple_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sqrt_req_t   req_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q;
  logic [32:0] rem_q;
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [34:0] r2;
  logic [34:0] trial;
  logic        ge;

  assign r2    = {rem_q, rad_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = r2 >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= req_i.radicand;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? 33'(r2 - trial) : r2[32:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: hw/rtl/sphere_plane_level_set_eval.sv
// top level: smoothed level-set value of a sphere union and a half-space
//
// a load transaction (cmd 0) stores one sphere (center, radius) in the table;
// loads to a slot at or above MAX_SPHERES are dropped.
// an evaluate transaction (cmd 1) gives one level = 1/(1+exp(dist/epsilon))
// as unsigned Q1.16, where dist is the least of |p - c| - r over the first
// sphere_count spheres and the signed plane distance along the normalized
// normal. all inputs are Q16.16. the block is busy for one evaluation at a
// time: per sphere, three squares on the shared multiplier and a pass through
// the square-root unit; for the plane term, the normal length and three 29-bit
// divides; then the exponential on the shared bit-serial divider: two 14-term
// series at 33 quotient bits a term, the exponent divide and the final divide,
// plus a multiply per whole unit of the clamped exponent. a finished level
// sits in the output register, so the next transaction can be taken while it
// waits. configuration writes are taken at any time but should only be made
// while idle. table entries that were never loaded read back as garbage.
module sphere_plane_level_set_eval
  import sple_pkg::*;
#(
  parameter int unsigned MAX_SPHERES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sple_item_if.sink           item_i,
  sple_result_if.source       result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int unsigned CntW = $clog2(MAX_SPHERES + 1);

  // configuration registers
  logic signed [31:0] plane_x_q, plane_y_q, plane_z_q;
  logic signed [31:0] normal_x_q, normal_y_q, normal_z_q;
  logic [30:0]        eps_q;
  logic [4:0]         sphere_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_x_q      <= '0;
      plane_y_q      <= '0;
      plane_z_q      <= '0;
      normal_x_q     <= '0;
      normal_y_q     <= NormalYReset;
      normal_z_q     <= '0;
      eps_q          <= EpsReset;
      sphere_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPlaneX:      plane_x_q      <= cfg_data_i;
        CfgPlaneY:      plane_y_q      <= cfg_data_i;
        CfgPlaneZ:      plane_z_q      <= cfg_data_i;
        CfgNormalX:     normal_x_q     <= cfg_data_i;
        CfgNormalY:     normal_y_q     <= cfg_data_i;
        CfgNormalZ:     normal_z_q     <= cfg_data_i;
        CfgEpsilon:     eps_q          <= cfg_data_i[30:0];
        CfgSphereCount: sphere_count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // state and datapath registers
  state_e state_q, state_d;

  logic signed [31:0] pt_x_q, pt_y_q, pt_z_q;
  logic signed [31:0] rd_cx_q, rd_cy_q, rd_cz_q;
  logic [30:0]        rd_r_q;
  logic [CntW-1:0]    idx_q, cnt_q;
  logic [31:0]        m_q [3];
  logic               shift_q;
  logic [1:0]         sub_q;
  logic [63:0]        sq_acc_q;
  logic               plane_q;
  logic [31:0]        len_q;
  logic signed [29:0] u_q;
  logic signed [63:0] dot_q;
  logic signed [35:0] dist_q;
  logic               have_q;
  logic [35:0]        dabs_q;
  logic [30:0]        eps_e_q;
  logic [4:0]         ip_q;
  logic [15:0]        frac_q;
  logic               cph_q;
  logic [32:0]        term_q;
  logic signed [34:0] sum_q;
  logic [3:0]         k_q;
  logic [16:0]        ser_f_q;
  logic [32:0]        c_q, e_q;
  logic [16:0]        res_q;
  logic signed [67:0] prod_q;
  logic               out_valid_q;
  logic [16:0]        out_level_q;

  // sphere table
  logic signed [31:0] cx_mem [MAX_SPHERES];
  logic signed [31:0] cy_mem [MAX_SPHERES];
  logic signed [31:0] cz_mem [MAX_SPHERES];
  logic [30:0]        r_mem  [MAX_SPHERES];

  logic item_acc;
  logic item_ready;
  assign item_acc = item_i.valid && item_ready;

  always_ff @(posedge clk_i) begin
    if (item_acc && item_i.cmd == CmdLoad && 32'(item_i.slot) < 32'(MAX_SPHERES)) begin
      cx_mem[IdxW'(item_i.slot)] <= item_i.pos_x;
      cy_mem[IdxW'(item_i.slot)] <= item_i.pos_y;
      cz_mem[IdxW'(item_i.slot)] <= item_i.pos_z;
      r_mem[IdxW'(item_i.slot)]  <= item_i.radius;
    end
    rd_cx_q <= cx_mem[idx_q[IdxW-1:0]];
    rd_cy_q <= cy_mem[idx_q[IdxW-1:0]];
    rd_cz_q <= cz_mem[idx_q[IdxW-1:0]];
    rd_r_q  <= r_mem[idx_q[IdxW-1:0]];
  end

  // shared units
  div_req_t         div_req;
  logic             div_done;
  logic [DivQW-1:0] div_quot;
  sqrt_req_t        sqrt_req;
  logic             sqrt_done;
  logic [31:0]      sqrt_root;

  sple_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  sple_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  // helper values
  logic [CntW-1:0]    cnt_eff;
  logic [CntW-1:0]    idx_nxt;
  logic signed [32:0] dx, dy, dz;
  logic [32:0]        mx, my, mz;
  logic               big;
  logic [31:0]        nmag [3];
  logic               nneg [3];
  logic signed [32:0] pdiff [3];
  logic [33:0]        norm;
  logic signed [35:0] sph_d;
  logic signed [35:0] pl_d;
  logic [35:0]        dabs;
  logic [30:0]        eps_e;
  logic signed [34:0] sum_nxt;
  logic signed [34:0] sum_cl;
  logic [33:0]        lvl_den;
  logic [63:0]        lvl_num;
  logic [29:0]        uq;
  logic signed [33:0] mul_a, mul_b;

  always_comb begin
    cnt_eff = (32'(sphere_count_q) > 32'(MAX_SPHERES)) ? CntW'(MAX_SPHERES)
                                                       : CntW'(sphere_count_q);
    idx_nxt = idx_q + CntW'(1);
    dx = 33'(pt_x_q) - 33'(rd_cx_q);
    dy = 33'(pt_y_q) - 33'(rd_cy_q);
    dz = 33'(pt_z_q) - 33'(rd_cz_q);
    mx = dx[32] ? 33'(-dx) : 33'(dx);
    my = dy[32] ? 33'(-dy) : 33'(dy);
    mz = dz[32] ? 33'(-dz) : 33'(dz);
    big = (mx[32:31] != 2'b00) || (my[32:31] != 2'b00) || (mz[32:31] != 2'b00);
    nneg[0] = normal_x_q[31];
    nneg[1] = normal_y_q[31];
    nneg[2] = normal_z_q[31];
    nmag[0] = nneg[0] ? 32'(-normal_x_q) : 32'(normal_x_q);
    nmag[1] = nneg[1] ? 32'(-normal_y_q) : 32'(normal_y_q);
    nmag[2] = nneg[2] ? 32'(-normal_z_q) : 32'(normal_z_q);
    pdiff[0] = 33'(plane_x_q) - 33'(pt_x_q);
    pdiff[1] = 33'(plane_y_q) - 33'(pt_y_q);
    pdiff[2] = 33'(plane_z_q) - 33'(pt_z_q);
    // undo the pre-shift of large differences
    norm  = shift_q ? {sqrt_root, 2'b00} : {2'b00, sqrt_root};
    sph_d = $signed({2'b00, norm}) - $signed({5'b0, rd_r_q});
    // floor of the dot product in Q16.16
    pl_d  = 36'(dot_q >>> UnitBits);
    dabs  = dist_q[35] ? 36'(-dist_q) : 36'(dist_q);
    eps_e = (eps_q == '0) ? 31'd1 : eps_q;
    sum_nxt = k_q[0] ? sum_q - $signed({2'b00, div_quot[32:0]})
                     : sum_q + $signed({2'b00, div_quot[32:0]});
    if (sum_q < 0) begin
      sum_cl = '0;
    end else if (sum_q > $signed(35'h1_0000_0000)) begin
      sum_cl = 35'sh1_0000_0000;
    end else begin
      sum_cl = sum_q;
    end
    lvl_den = {1'b0, e_q} + 34'h1_0000_0000;
    lvl_num = (dist_q[35] ? 64'h1_0000_0000_0000 : (64'(e_q) << LevelBits))
              + 64'(lvl_den >> 1);
    uq = {1'b0, div_quot[28:0]};
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_acc && item_i.cmd == CmdEval) begin
          state_d = (cnt_eff != '0) ? ST_SPH_RD : ST_NORM_LOAD;
        end
      end
      ST_SPH_RD:    state_d = ST_SPH_DIFF;
      ST_SPH_DIFF:  state_d = ST_SQ_MUL;
      ST_NORM_LOAD: state_d = ST_SQ_MUL;
      ST_SQ_MUL:    state_d = ST_SQ_ACC;
      ST_SQ_ACC:    state_d = (sub_q == 2'd2) ? ST_SQRT_GO : ST_SQ_MUL;
      ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          if (!plane_q) begin
            state_d = (idx_nxt == cnt_q) ? ST_NORM_LOAD : ST_SPH_RD;
          end else begin
            state_d = (sqrt_root == '0) ? ST_EXP_START : ST_UNIT_GO;
          end
        end
      end
      ST_UNIT_GO:   state_d = ST_UNIT_WAIT;
      ST_UNIT_WAIT: if (div_done) state_d = ST_DOT_MUL;
      ST_DOT_MUL:   state_d = ST_DOT_ACC;
      ST_DOT_ACC:   state_d = (sub_q == 2'd2) ? ST_PLANE_DONE : ST_UNIT_GO;
      ST_PLANE_DONE: state_d = ST_EXP_START;
      ST_EXP_START: begin
        if (!have_q) begin
          state_d = ST_OUT;
        end else if (dabs >= {1'b0, eps_e, 4'b0000}) begin
          state_d = ST_SER_INIT;
        end else begin
          state_d = ST_EXP_GO;
        end
      end
      ST_EXP_GO:       state_d = ST_EXP_WAIT;
      ST_EXP_WAIT:     if (div_done) state_d = ST_SER_INIT;
      ST_SER_INIT:     state_d = ST_SER_MUL;
      ST_SER_MUL:      state_d = ST_SER_DIV_GO;
      ST_SER_DIV_GO:   state_d = ST_SER_DIV_WAIT;
      ST_SER_DIV_WAIT: begin
        if (div_done) begin
          state_d = (k_q == 4'(SerTerms)) ? ST_SER_END : ST_SER_MUL;
        end
      end
      ST_SER_END: begin
        if (cph_q) begin
          state_d = ST_SER_INIT;
        end else begin
          state_d = (ip_q == '0) ? ST_LVL_GO : ST_POW_MUL;
        end
      end
      ST_POW_MUL:  state_d = ST_POW_ACC;
      ST_POW_ACC:  state_d = (ip_q == 5'd1) ? ST_LVL_GO : ST_POW_MUL;
      ST_LVL_GO:   state_d = ST_LVL_WAIT;
      ST_LVL_WAIT: if (div_done) state_d = ST_OUT;
      ST_OUT:      if (!out_valid_q || result_o.ready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // unit requests and multiplier operands
  always_comb begin
    item_ready        = (state_q == ST_IDLE);
    div_req           = '0;
    sqrt_req.start    = (state_q == ST_SQRT_GO);
    sqrt_req.radicand = sq_acc_q;
    mul_a             = '0;
    mul_b             = '0;
    case (state_q)
      ST_UNIT_GO: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(nmag[sub_q]) << UnitBits;
        div_req.den   = 34'(len_q);
        div_req.qbits = QbUnit;
      end
      ST_EXP_GO: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(dabs_q) << 16;
        div_req.den   = 34'(eps_e_q);
        div_req.qbits = QbExp;
      end
      ST_SER_DIV_GO: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(prod_q[63:16]);
        div_req.den   = 34'(k_q);
        div_req.qbits = QbSeries;
      end
      ST_LVL_GO: begin
        div_req.start = 1'b1;
        div_req.num   = lvl_num;
        div_req.den   = lvl_den;
        div_req.qbits = QbLevel;
      end
      ST_SQ_MUL: begin
        mul_a = $signed({2'b00, m_q[sub_q]});
        mul_b = $signed({2'b00, m_q[sub_q]});
      end
      ST_DOT_MUL: begin
        mul_a = 34'(pdiff[sub_q]);
        mul_b = 34'(u_q);
      end
      ST_SER_MUL: begin
        mul_a = $signed({1'b0, term_q});
        mul_b = $signed({17'b0, ser_f_q});
      end
      ST_POW_MUL: begin
        mul_a = $signed({1'b0, e_q});
        mul_b = $signed({1'b0, c_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && (!out_valid_q || result_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= 68'(mul_a) * 68'(mul_b);
    if (state_q == ST_OUT && (!out_valid_q || result_o.ready)) begin
      out_level_q <= res_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (item_acc) begin
          pt_x_q  <= item_i.pos_x;
          pt_y_q  <= item_i.pos_y;
          pt_z_q  <= item_i.pos_z;
          idx_q   <= '0;
          cnt_q   <= cnt_eff;
          have_q  <= 1'b0;
          plane_q <= 1'b0;
        end
      end
      ST_SPH_DIFF: begin
        // keep squares in range when any difference is large
        m_q[0]   <= big ? {1'b0, mx[32:2]} : mx[31:0];
        m_q[1]   <= big ? {1'b0, my[32:2]} : my[31:0];
        m_q[2]   <= big ? {1'b0, mz[32:2]} : mz[31:0];
        shift_q  <= big;
        sub_q    <= '0;
        sq_acc_q <= '0;
      end
      ST_NORM_LOAD: begin
        m_q[0]   <= nmag[0];
        m_q[1]   <= nmag[1];
        m_q[2]   <= nmag[2];
        shift_q  <= 1'b0;
        plane_q  <= 1'b1;
        sub_q    <= '0;
        sq_acc_q <= '0;
      end
      ST_SQ_ACC: begin
        sq_acc_q <= sq_acc_q + prod_q[63:0];
        sub_q    <= sub_q + 2'd1;
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          if (!plane_q) begin
            if (!have_q || sph_d < dist_q) begin
              dist_q <= sph_d;
              have_q <= 1'b1;
            end
            idx_q <= idx_nxt;
          end else begin
            len_q <= sqrt_root;
            sub_q <= '0;
            dot_q <= '0;
          end
        end
      end
      ST_UNIT_WAIT: begin
        if (div_done) begin
          u_q <= nneg[sub_q] ? 30'(-$signed(uq)) : $signed(uq);
        end
      end
      ST_DOT_ACC: begin
        dot_q <= dot_q + $signed(prod_q[63:0]);
        sub_q <= sub_q + 2'd1;
      end
      ST_PLANE_DONE: begin
        if (!have_q || pl_d < dist_q) begin
          dist_q <= pl_d;
          have_q <= 1'b1;
        end
      end
      ST_EXP_START: begin
        dabs_q  <= dabs;
        eps_e_q <= eps_e;
        cph_q   <= 1'b1;
        res_q   <= '0;
        // exponent clamped at 16.0
        ip_q    <= 5'd16;
        frac_q  <= '0;
      end
      ST_EXP_WAIT: begin
        if (div_done) begin
          ip_q   <= div_quot[20:16];
          frac_q <= div_quot[15:0];
        end
      end
      ST_SER_INIT: begin
        term_q  <= 33'h1_0000_0000;
        sum_q   <= 35'sh1_0000_0000;
        k_q     <= 4'd1;
        ser_f_q <= cph_q ? 17'h1_0000 : {1'b0, frac_q};
      end
      ST_SER_DIV_WAIT: begin
        if (div_done) begin
          term_q <= div_quot[32:0];
          sum_q  <= sum_nxt;
          k_q    <= k_q + 4'd1;
        end
      end
      ST_SER_END: begin
        if (cph_q) begin
          c_q   <= sum_cl[32:0];
          cph_q <= 1'b0;
        end else begin
          e_q <= sum_cl[32:0];
        end
      end
      ST_POW_ACC: begin
        e_q  <= prod_q[64:32];
        ip_q <= ip_q - 5'd1;
      end
      ST_LVL_WAIT: begin
        if (div_done) begin
          res_q <= div_quot[16:0];
        end
      end
      default: ;
    endcase
  end

  assign item_i.ready    = item_ready;
  assign result_o.valid  = out_valid_q;
  assign result_o.level  = out_level_q;

endmodule
